[hdl/wsfh_pkg.sv]
package wsfh_pkg;

    localparam logic [7:0] FIN_MASK    = 8'h80;
    localparam logic [7:0] OPC_MASK    = 8'h0F;
    localparam logic [7:0] LEN_MASK    = 8'h7F;
    localparam logic [7:0] RSV_MASK    = 8'h70;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] POS_FIRST  = 4'd0;
    localparam logic [3:0] POS_SECOND = 4'd1;
    localparam logic [3:0] BASE_LEN   = 4'd2;
    localparam logic [3:0] KEY_LEN    = 4'd4;

    localparam logic [3:0] OPC_CONT  = 4'h0;
    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_BIN   = 4'h2;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'hA;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_RSV = 2'd1,
        ST_OPC = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] data_len;
        logic [31:0] key_word;
        logic [3:0]  header_len;
        t_status     status;
    } t_result;

    function automatic logic [3:0] ext_len(input logic [7:0] second);
        logic [6:0] code;
        code = second[6:0];
        if (code == LEN_CODE_16) begin
            return 4'd2;
        end else if (code == LEN_CODE_64) begin
            return 4'd8;
        end
        return 4'd0;
    endfunction

    function automatic logic [3:0] hdr_len(input logic [7:0] second);
        return BASE_LEN + ext_len(second) + ((second & FIN_MASK) != 8'h00 ? KEY_LEN : 4'd0);
    endfunction

    function automatic logic opcode_known(input logic [3:0] op);
        return op == OPC_CONT || op == OPC_TEXT || op == OPC_BIN ||
               op == OPC_CLOSE || op == OPC_PING || op == OPC_PONG;
    endfunction

endpackage

[hdl/wsfh_in_stage.sv]
module wsfh_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wsfh_pkg::t_in_item i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output wsfh_pkg::t_in_item o_item
);

    logic               r_valid;
    logic               n_valid;
    wsfh_pkg::t_in_item r_item;
    logic               load;

    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/wsfh_parse.sv]
module wsfh_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  wsfh_pkg::t_in_item i_item,
    output logic               o_emit,
    output wsfh_pkg::t_result  o_result
);

    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic [7:0]  r_first;
    logic [7:0]  n_first;
    logic [7:0]  r_second;
    logic [7:0]  n_second;
    logic [63:0] r_len;
    logic [63:0] n_len;
    logic [31:0] r_key;
    logic [31:0] n_key;
    logic [3:0]  pos_eff;
    logic [3:0]  pos_inc;
    logic        emit;

    assign pos_eff = i_item.restart ? wsfh_pkg::POS_FIRST : r_pos;
    assign pos_inc = pos_eff + 4'd1;

    always_comb begin
        n_pos    = r_pos;
        n_first  = r_first;
        n_second = r_second;
        n_len    = r_len;
        n_key    = r_key;
        emit     = 1'b0;
        priority if (pos_eff == wsfh_pkg::POS_FIRST) begin
            n_first  = i_item.data_byte;
            n_second = 8'h00;
            n_len    = 64'd0;
            n_key    = 32'd0;
            n_pos    = pos_inc;
        end else if (pos_eff == wsfh_pkg::POS_SECOND) begin
            n_second = i_item.data_byte;
            n_pos    = pos_inc;
            emit     = wsfh_pkg::hdr_len(i_item.data_byte) == wsfh_pkg::BASE_LEN;
        end else begin
            if (pos_eff < wsfh_pkg::BASE_LEN + wsfh_pkg::ext_len(r_second)) begin
                n_len = {r_len[55:0], i_item.data_byte};
            end else begin
                n_key = {r_key[23:0], i_item.data_byte};
            end
            n_pos = pos_inc;
            emit  = pos_inc >= wsfh_pkg::hdr_len(r_second);
        end
        if (emit) begin
            n_pos = wsfh_pkg::POS_FIRST;
        end
    end

    always_comb begin
        o_result.fin        = (n_first & wsfh_pkg::FIN_MASK) != 8'h00;
        o_result.opcode     = n_first[3:0];
        o_result.masked     = (n_second & wsfh_pkg::FIN_MASK) != 8'h00;
        o_result.data_len   = (n_second[6:0] < wsfh_pkg::LEN_CODE_16)
                            ? {57'd0, n_second[6:0]} : n_len;
        o_result.key_word   = o_result.masked ? n_key : 32'd0;
        o_result.header_len = wsfh_pkg::hdr_len(n_second);
        if ((n_first & wsfh_pkg::RSV_MASK) != 8'h00) begin
            o_result.status = wsfh_pkg::ST_RSV;
        end else if (!wsfh_pkg::opcode_known(n_first[3:0])) begin
            o_result.status = wsfh_pkg::ST_OPC;
        end else begin
            o_result.status = wsfh_pkg::ST_OK;
        end
    end

    assign o_emit = i_advance && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= wsfh_pkg::POS_FIRST;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_len    <= n_len;
            r_key    <= n_key;
        end
    end

endmodule

[hdl/wsfh_out_stage.sv]
module wsfh_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsfh_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output wsfh_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    wsfh_pkg::t_result r_result;

    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hdl/websocket_frame_header_parser.sv]
// Channel  Handshake                 Payload
// in       i_in_valid / o_in_ready   i_data_byte, i_restart
// out      o_out_valid / i_out_ready o_fin, o_opcode, o_masked, o_data_len,
//                                    o_key_word, o_header_len, o_status
//
// One item per cycle while results are taken; a header's last byte passes the
// input register, then the result register, before o_out_valid rises.
// Reset is synchronous and active low; it returns the parser to a first byte.
// While a result waits, one more item is held in the input register, then
// o_in_ready drops until the result is taken.
module websocket_frame_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fin,
    output logic [3:0]  o_opcode,
    output logic        o_masked,
    output logic [63:0] o_data_len,
    output logic [31:0] o_key_word,
    output logic [3:0]  o_header_len,
    output logic [1:0]  o_status
);

    wsfh_pkg::t_in_item in_item;
    wsfh_pkg::t_in_item stage_item;
    wsfh_pkg::t_result  parse_result;
    wsfh_pkg::t_result  out_result;
    logic               stage_valid;
    logic               out_space;
    logic               advance;
    logic               emit;

    assign in_item.data_byte = i_data_byte;
    assign in_item.restart   = i_restart;
    assign advance           = stage_valid && out_space;

    wsfh_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    wsfh_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_emit    (emit),
        .o_result  (parse_result)
    );

    wsfh_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (parse_result),
        .o_space  (out_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_fin        = out_result.fin;
    assign o_opcode     = out_result.opcode;
    assign o_masked     = out_result.masked;
    assign o_data_len   = out_result.data_len;
    assign o_key_word   = out_result.key_word;
    assign o_header_len = out_result.header_len;
    assign o_status     = out_result.status;

endmodule

[hdl/wsfh_checker.sv]
module wsfh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_restart,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_fin,
    input logic [3:0]  o_opcode,
    input logic        o_masked,
    input logic [63:0] o_data_len,
    input logic [31:0] o_key_word,
    input logic [3:0]  o_header_len,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_data_len) && $stable(o_key_word))
        else $error("result changed while stalled");

    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_header_len == 4'd2 || o_header_len == 4'd4 ||
                        o_header_len == 4'd6 || o_header_len == 4'd8 ||
                        o_header_len == 4'd10 || o_header_len == 4'd14)
        else $error("illegal header length");

    a_short_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_len == 4'd2 |->
            !o_masked && o_data_len < 64'd126 && o_key_word == 32'd0)
        else $error("short header inconsistent with fields");

    a_key_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_masked |-> o_header_len != 4'd2 && o_header_len != 4'd4 &&
                                    o_status != 2'd3)
        else $error("masked header too short or bad status");

endmodule

bind websocket_frame_header_parser wsfh_checker u_chk (.*);
